// File: rtl/block_tree_prefix_sum_access_assert.svh
// ----------------------------------------------------------------------------
// Block tree prefix sum access: assertion macros
// Shared property shorthands on clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef BLOCK_TREE_PREFIX_SUM_ACCESS_ASSERT_SVH
`define BLOCK_TREE_PREFIX_SUM_ACCESS_ASSERT_SVH

// same-cycle implication
`define BTPS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define BTPS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/btps_pkg.sv
// ----------------------------------------------------------------------------
// Block tree prefix sum access: package
// Shared widths, codes, walk states and status type.
// ----------------------------------------------------------------------------
package btps_pkg;

	localparam int MAX_LEVELS_DEF    = 8;
	localparam int LEVEL_ENTRIES_DEF = 1024;
	localparam int LEAF_ENTRIES_DEF  = 4096;
	localparam int DICT_ENTRIES_DEF  = 4096;

	localparam int SUM_W   = 64;
	localparam int POS_W   = 24;
	localparam int ARITY_W = 5;
	localparam int LEN_W   = 17;
	localparam int LVC_W   = 4;
	localparam int OFF_W   = 32;
	localparam int CODE_W  = 13;
	localparam int DVD_W   = 33;
	localparam int DSR_W   = 17;
	localparam int CFG_W   = 17;
	localparam int CIDX_W  = 2;

	localparam logic KIND_QUERY = 1'b0;
	localparam logic KIND_LOAD  = 1'b1;

	typedef enum logic [CIDX_W-1:0] {
		REG_ARITY,
		REG_TOP_LEN,
		REG_LEVELS
	} reg_idx_t;

	typedef enum logic [2:0] {
		TBL_TOP,
		TBL_FLAG,
		TBL_BSUM,
		TBL_OFF,
		TBL_SEC,
		TBL_CODE,
		TBL_DICT
	} tbl_sel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_TDIV,
		S_TREAD,
		S_LOOP,
		S_RANK,
		S_RDEC,
		S_LDIV,
		S_CSTART,
		S_CDIV,
		S_CSUM,
		S_BREAD,
		S_BDIV,
		S_BSUB,
		S_LEAF,
		S_LCHK,
		S_CODE,
		S_DICT,
		S_DONE
	} walk_state_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
		logic res_oor;
	} walk_stat_t;

endpackage

// File: rtl/btps_ram.sv
// ----------------------------------------------------------------------------
// Block tree prefix sum access: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module btps_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/btps_div.sv
// ----------------------------------------------------------------------------
// Block tree prefix sum access: serial divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module btps_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [btps_pkg::DVD_W-1:0] dividend,
	input  logic [btps_pkg::DSR_W-1:0] divisor,
	output logic                       done,
	output logic [btps_pkg::DVD_W-1:0] quotient,
	output logic [btps_pkg::DSR_W-1:0] remainder
);

	localparam int DVD_W = btps_pkg::DVD_W;
	localparam int DSR_W = btps_pkg::DSR_W;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W:0]   shifted;
	logic [DSR_W+1:0] diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
	assign ge      = !diff[DSR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: rtl/btps_walk.sv
// ----------------------------------------------------------------------------
// Block tree prefix sum access: query walker
// Sequencer that walks the tree levels over the table memories.
// ----------------------------------------------------------------------------
module btps_walk #(
	parameter int MAX_LEVELS    = btps_pkg::MAX_LEVELS_DEF,
	parameter int LEVEL_ENTRIES = btps_pkg::LEVEL_ENTRIES_DEF,
	parameter int LEAF_ENTRIES  = btps_pkg::LEAF_ENTRIES_DEF,
	parameter int DICT_ENTRIES  = btps_pkg::DICT_ENTRIES_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [btps_pkg::POS_W-1:0]                  query_position,
	input  logic [btps_pkg::ARITY_W-1:0]                arity,
	input  logic [btps_pkg::LEN_W-1:0]                  top_len,
	input  logic [btps_pkg::LVC_W-1:0]                  lvl_count,
	output btps_pkg::walk_stat_t                        stat,
	output logic [btps_pkg::SUM_W-1:0]                  res_sum,
	input  logic                                        res_take,
	output logic [$clog2(LEVEL_ENTRIES)-1:0]            top_raddr,
	input  logic [btps_pkg::SUM_W-1:0]                  top_rdata,
	output logic [$clog2(MAX_LEVELS*LEVEL_ENTRIES)-1:0] flag_raddr,
	input  logic                                        flag_rdata,
	output logic [$clog2(MAX_LEVELS*LEVEL_ENTRIES)-1:0] bsum_raddr,
	input  logic [btps_pkg::SUM_W-1:0]                  bsum_rdata,
	output logic [$clog2(MAX_LEVELS*LEVEL_ENTRIES)-1:0] boff_raddr,
	input  logic [btps_pkg::OFF_W-1:0]                  off_rdata,
	input  logic [btps_pkg::SUM_W-1:0]                  sec_rdata,
	output logic [$clog2(LEAF_ENTRIES)-1:0]             code_raddr,
	input  logic [btps_pkg::CODE_W-1:0]                 code_rdata,
	output logic [$clog2(DICT_ENTRIES)-1:0]             dict_raddr,
	input  logic [btps_pkg::SUM_W-1:0]                  dict_rdata
);

	localparam int LIW    = $clog2(LEVEL_ENTRIES);
	localparam int AW     = $clog2(MAX_LEVELS * LEVEL_ENTRIES);
	localparam int LAW    = $clog2(LEAF_ENTRIES);
	localparam int DAW    = $clog2(DICT_ENTRIES);
	localparam int KW     = $clog2(LEVEL_ENTRIES + 1);
	localparam int LVW    = $clog2(MAX_LEVELS + 1);
	localparam int STW    = $clog2(2 * MAX_LEVELS + 2);
	localparam int BW     = btps_pkg::DVD_W;
	localparam int LW     = btps_pkg::LEN_W;
	localparam int AR_W   = btps_pkg::ARITY_W;
	localparam int SW     = btps_pkg::SUM_W;
	localparam int LEAF_W = BW + LW + 1;

	btps_pkg::walk_state_t state_q, state_d;

	logic [AR_W-1:0]   ar_q;
	logic [LW-1:0]     len_q;
	logic [LVW-1:0]    levels_q;
	logic [LVW-1:0]    level_q;
	logic [STW-1:0]    steps_q;
	logic [BW-1:0]     blk_q;
	logic [LW-1:0]     i_q;
	logic [SW-1:0]     sum_q;
	logic [KW-1:0]     rank_q;
	logic              flag_q;
	logic [KW-1:0]     k_q;
	logic              rv_s1;
	logic [KW-1:0]     rk_s1;
	logic [BW-1:0]     c_q;
	logic [BW-1:0]     cend_q;
	logic              cv_s1;
	logic [LEAF_W-1:0] leaf_q;
	logic              oor_q;

	logic              div_start;
	logic [BW-1:0]     div_dvd;
	logic [LW-1:0]     div_dsr;
	logic              div_done;
	logic [BW-1:0]     div_quo;
	logic [LW-1:0]     div_rem;

	logic [AR_W-1:0]   ar_eff;
	logic [LW-1:0]     len0;
	logic [LVW-1:0]    levels_eff;
	logic [31:0]       lvl_base;
	logic [BW-1:0]     le_b;
	logic              rank_issue;
	logic              csum_issue;
	logic              csum_oob;
	logic              csum_end;
	logic [BW-1:0]     first;
	logic [LW:0]       bdiv_sum;
	logic              bdiv_wrap;
	logic              last_level;
	logic              step_over;
	logic              fail;

	btps_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		ar_eff = (arity < AR_W'(2)) ? AR_W'(2) : arity;
		len0   = (top_len == '0) ? LW'(1) : top_len;
		if (lvl_count == '0) begin
			levels_eff = LVW'(1);
		end else if (32'(lvl_count) > 32'(MAX_LEVELS)) begin
			levels_eff = LVW'(MAX_LEVELS);
		end else begin
			levels_eff = LVW'(lvl_count);
		end
	end

	assign lvl_base   = 32'(level_q) * 32'(LEVEL_ENTRIES);
	assign le_b       = BW'(LEVEL_ENTRIES);
	assign rank_issue = BW'(k_q) <= blk_q;
	assign csum_issue = c_q < cend_q;
	assign csum_oob   = csum_issue && (c_q >= le_b);
	assign csum_end   = !csum_issue && !cv_s1;
	assign first      = BW'(rank_q) * BW'(ar_q);
	assign bdiv_sum   = (LW+1)'(i_q) + (LW+1)'(div_rem);
	assign bdiv_wrap  = bdiv_sum >= (LW+1)'(len_q);
	assign last_level = (32'(level_q) + 32'd1) >= 32'(levels_q);
	assign step_over  = (32'(steps_q) + 32'd1) > 32'(2 * MAX_LEVELS);

	assign top_raddr  = div_quo[LIW-1:0];
	assign flag_raddr = AW'(lvl_base + 32'(k_q));
	assign bsum_raddr = (state_q == btps_pkg::S_CSUM)
		? AW'(lvl_base + 32'(LEVEL_ENTRIES) + c_q[31:0])
		: AW'(lvl_base + div_quo[31:0]);
	assign boff_raddr = AW'(lvl_base + blk_q[31:0] - 32'(rank_q));
	assign code_raddr = leaf_q[LAW-1:0];
	assign dict_raddr = DAW'(code_rdata);

	always_comb begin
		fail = 1'b0;
		case (state_q)
			btps_pkg::S_TDIV: fail = div_done && (div_quo >= le_b);
			btps_pkg::S_LOOP: fail = !last_level && (step_over || blk_q >= le_b);
			btps_pkg::S_CSUM: fail = csum_oob;
			btps_pkg::S_BDIV: fail = div_done && !bdiv_wrap && (div_quo >= le_b);
			btps_pkg::S_LCHK: fail = leaf_q >= LEAF_W'(LEAF_ENTRIES);
			btps_pkg::S_CODE: fail = 32'(code_rdata) >= 32'(DICT_ENTRIES);
			default:          fail = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			btps_pkg::S_IDLE: begin
				if (start) state_d = btps_pkg::S_TDIV;
			end
			btps_pkg::S_TDIV: begin
				if (div_done) state_d = fail ? btps_pkg::S_DONE : btps_pkg::S_TREAD;
			end
			btps_pkg::S_TREAD: state_d = btps_pkg::S_LOOP;
			btps_pkg::S_LOOP: begin
				if (last_level) state_d = btps_pkg::S_LEAF;
				else if (fail) state_d = btps_pkg::S_DONE;
				else state_d = btps_pkg::S_RANK;
			end
			btps_pkg::S_RANK: begin
				if (rv_s1 && BW'(rk_s1) == blk_q) state_d = btps_pkg::S_RDEC;
			end
			btps_pkg::S_RDEC: state_d = flag_q ? btps_pkg::S_LDIV : btps_pkg::S_BREAD;
			btps_pkg::S_LDIV: begin
				if (div_done) state_d = btps_pkg::S_CSTART;
			end
			btps_pkg::S_CSTART: state_d = btps_pkg::S_CDIV;
			btps_pkg::S_CDIV: begin
				if (div_done) state_d = btps_pkg::S_CSUM;
			end
			btps_pkg::S_CSUM: begin
				if (fail) state_d = btps_pkg::S_DONE;
				else if (csum_end) state_d = btps_pkg::S_LOOP;
			end
			btps_pkg::S_BREAD: state_d = btps_pkg::S_BDIV;
			btps_pkg::S_BDIV: begin
				if (div_done) begin
					if (bdiv_wrap) state_d = btps_pkg::S_LOOP;
					else if (fail) state_d = btps_pkg::S_DONE;
					else state_d = btps_pkg::S_BSUB;
				end
			end
			btps_pkg::S_BSUB: state_d = btps_pkg::S_LOOP;
			btps_pkg::S_LEAF: state_d = btps_pkg::S_LCHK;
			btps_pkg::S_LCHK: state_d = fail ? btps_pkg::S_DONE : btps_pkg::S_CODE;
			btps_pkg::S_CODE: state_d = fail ? btps_pkg::S_DONE : btps_pkg::S_DICT;
			btps_pkg::S_DICT: state_d = btps_pkg::S_DONE;
			btps_pkg::S_DONE: begin
				if (res_take) state_d = btps_pkg::S_IDLE;
			end
			default: state_d = btps_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd   = BW'(len_q);
		div_dsr   = LW'(ar_q);
		unique case (state_q)
			btps_pkg::S_IDLE: begin
				div_start = start;
				div_dvd   = BW'(query_position);
				div_dsr   = len0;
			end
			btps_pkg::S_RDEC: begin
				div_start = flag_q;
			end
			btps_pkg::S_CSTART: begin
				div_start = 1'b1;
				div_dvd   = BW'(i_q);
				div_dsr   = len_q;
			end
			btps_pkg::S_BREAD: begin
				div_start = 1'b1;
				div_dvd   = BW'(off_rdata);
				div_dsr   = len_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
		stat.idle      = state_q == btps_pkg::S_IDLE;
		stat.res_valid = state_q == btps_pkg::S_DONE;
		stat.res_oor   = oor_q;
		res_sum        = oor_q ? '0 : sum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btps_pkg::S_IDLE;
			rv_s1   <= 1'b0;
			cv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= (state_q == btps_pkg::S_RANK) && rank_issue;
			cv_s1   <= (state_q == btps_pkg::S_CSUM) && csum_issue && !csum_oob;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			btps_pkg::S_IDLE: begin
				if (start) begin
					ar_q     <= ar_eff;
					len_q    <= len0;
					levels_q <= levels_eff;
					level_q  <= '0;
					steps_q  <= '0;
					sum_q    <= '0;
					oor_q    <= 1'b0;
				end
			end
			btps_pkg::S_TDIV: begin
				if (div_done) begin
					blk_q <= div_quo;
					i_q   <= div_rem;
				end
			end
			btps_pkg::S_TREAD: sum_q <= top_rdata;
			btps_pkg::S_LOOP: begin
				if (!last_level) begin
					steps_q <= steps_q + 1'b1;
					k_q     <= '0;
					rank_q  <= '0;
				end
			end
			btps_pkg::S_RANK: begin
				if (rank_issue) k_q <= k_q + 1'b1;
				rk_s1 <= k_q;
				if (rv_s1) begin
					if (BW'(rk_s1) == blk_q) flag_q <= flag_rdata;
					else rank_q <= rank_q + KW'(flag_rdata);
				end
			end
			btps_pkg::S_LDIV: begin
				if (div_done) len_q <= (div_quo == '0) ? LW'(1) : div_quo[LW-1:0];
			end
			btps_pkg::S_CDIV: begin
				if (div_done) begin
					i_q    <= div_rem;
					c_q    <= first;
					cend_q <= first + div_quo;
				end
			end
			btps_pkg::S_CSUM: begin
				if (csum_issue && !csum_oob) c_q <= c_q + 1'b1;
				if (cv_s1) sum_q <= sum_q + bsum_rdata;
				if (csum_end) begin
					blk_q   <= cend_q;
					level_q <= level_q + 1'b1;
				end
			end
			btps_pkg::S_BREAD: sum_q <= sum_q + sec_rdata;
			btps_pkg::S_BDIV: begin
				if (div_done) begin
					if (bdiv_wrap) begin
						blk_q <= div_quo + 1'b1;
						i_q   <= LW'(bdiv_sum - (LW+1)'(len_q));
					end else begin
						blk_q <= div_quo;
						i_q   <= bdiv_sum[LW-1:0];
					end
				end
			end
			btps_pkg::S_BSUB: sum_q <= sum_q - bsum_rdata;
			btps_pkg::S_LEAF: leaf_q <= LEAF_W'(i_q) + LEAF_W'(blk_q) * LEAF_W'(len_q);
			btps_pkg::S_DICT: sum_q <= sum_q + dict_rdata;
			default: ;
		endcase
		if (fail) oor_q <= 1'b1;
	end

endmodule

// File: rtl/block_tree_prefix_sum_access.sv
// ----------------------------------------------------------------------------
// Block tree prefix sum access: top level
// A query walks each level with rank counting over flags 0 to blk of the
// flag memory (one flag per cycle) and one or two serial divisions, and
// adds up the child sums that it skips over.
// A load item gives no result. After reset the flag memory is cleared,
// and no item is taken while it clears.
// ----------------------------------------------------------------------------
`include "block_tree_prefix_sum_access_assert.svh"

module block_tree_prefix_sum_access #(
	parameter int MAX_LEVELS    = btps_pkg::MAX_LEVELS_DEF,
	parameter int LEVEL_ENTRIES = btps_pkg::LEVEL_ENTRIES_DEF,
	parameter int LEAF_ENTRIES  = btps_pkg::LEAF_ENTRIES_DEF,
	parameter int DICT_ENTRIES  = btps_pkg::DICT_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [btps_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [btps_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [btps_pkg::POS_W-1:0]    query_position,
	input  logic [2:0]                    table_select,
	input  logic [2:0]                    level_number,
	input  logic [11:0]                   entry_index,
	input  logic signed [63:0]            entry_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [63:0]            prefix_sum,
	output logic                          out_of_range
);

	localparam int LIW   = $clog2(LEVEL_ENTRIES);
	localparam int TOTAL = MAX_LEVELS * LEVEL_ENTRIES;
	localparam int AW    = $clog2(TOTAL);
	localparam int LAW   = $clog2(LEAF_ENTRIES);
	localparam int DAW   = $clog2(DICT_ENTRIES);
	localparam int SW    = btps_pkg::SUM_W;

	logic [btps_pkg::ARITY_W-1:0] arity_q;
	logic [btps_pkg::LEN_W-1:0]   top_len_q;
	logic [btps_pkg::LVC_W-1:0]   lvl_count_q;

	logic          clearing_q;
	logic [AW-1:0] clr_q;

	logic          out_valid_q;
	logic [SW-1:0] prefix_sum_q;
	logic          out_of_range_q;

	btps_pkg::walk_stat_t stat;
	logic [SW-1:0]        res_sum;
	logic                 res_take;
	logic                 accept;
	logic                 load;
	logic                 start;

	logic [31:0]   idx32;
	logic [AW-1:0] slot;
	logic          level_ok;
	logic          we_top, we_flag, we_bsum, we_off, we_sec, we_code, we_dict;

	logic [LIW-1:0]             top_raddr;
	logic [SW-1:0]              top_rdata;
	logic [AW-1:0]              flag_raddr;
	logic                       flag_rdata;
	logic [AW-1:0]              bsum_raddr;
	logic [SW-1:0]              bsum_rdata;
	logic [AW-1:0]              boff_raddr;
	logic [btps_pkg::OFF_W-1:0] off_rdata;
	logic [SW-1:0]              sec_rdata;
	logic [LAW-1:0]             code_raddr;
	logic [btps_pkg::CODE_W-1:0] code_rdata;
	logic [DAW-1:0]             dict_raddr;
	logic [SW-1:0]              dict_rdata;

	assign in_ready = stat.idle && !clearing_q;
	assign accept   = in_valid && in_ready;
	assign load     = accept && (kind == btps_pkg::KIND_LOAD);
	assign start    = accept && (kind == btps_pkg::KIND_QUERY);
	assign res_take = stat.res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arity_q     <= btps_pkg::ARITY_W'(2);
			top_len_q   <= btps_pkg::LEN_W'(16);
			lvl_count_q <= btps_pkg::LVC_W'(1);
		end else if (cfg_write) begin
			unique case (btps_pkg::reg_idx_t'(cfg_index))
				btps_pkg::REG_ARITY:   arity_q     <= cfg_data[btps_pkg::ARITY_W-1:0];
				btps_pkg::REG_TOP_LEN: top_len_q   <= cfg_data[btps_pkg::LEN_W-1:0];
				btps_pkg::REG_LEVELS:  lvl_count_q <= cfg_data[btps_pkg::LVC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(TOTAL - 1)) clearing_q <= 1'b0;
		end
	end

	assign idx32    = 32'(entry_index);
	assign slot     = AW'(32'(level_number) * 32'(LEVEL_ENTRIES) + idx32);
	assign level_ok = (32'(level_number) < 32'(MAX_LEVELS)) && (idx32 < 32'(LEVEL_ENTRIES));

	always_comb begin
		we_top  = 1'b0;
		we_flag = 1'b0;
		we_bsum = 1'b0;
		we_off  = 1'b0;
		we_sec  = 1'b0;
		we_code = 1'b0;
		we_dict = 1'b0;
		unique case (btps_pkg::tbl_sel_t'(table_select))
			btps_pkg::TBL_TOP:  we_top  = load && (idx32 < 32'(LEVEL_ENTRIES));
			btps_pkg::TBL_FLAG: we_flag = load && level_ok;
			btps_pkg::TBL_BSUM: we_bsum = load && level_ok;
			btps_pkg::TBL_OFF:  we_off  = load && level_ok;
			btps_pkg::TBL_SEC:  we_sec  = load && level_ok;
			btps_pkg::TBL_CODE: we_code = load && (idx32 < 32'(LEAF_ENTRIES));
			btps_pkg::TBL_DICT: we_dict = load && (idx32 < 32'(DICT_ENTRIES));
			default: ;
		endcase
	end

	btps_ram #(.WIDTH(SW), .DEPTH(LEVEL_ENTRIES)) u_top (
		.clk(clk), .we(we_top), .waddr(idx32[LIW-1:0]), .wdata(entry_value),
		.raddr(top_raddr), .rdata(top_rdata)
	);

	btps_ram #(.WIDTH(1), .DEPTH(TOTAL)) u_flag (
		.clk(clk), .we(we_flag || clearing_q), .waddr(clearing_q ? clr_q : slot),
		.wdata(!clearing_q && entry_value[0]), .raddr(flag_raddr), .rdata(flag_rdata)
	);

	btps_ram #(.WIDTH(SW), .DEPTH(TOTAL)) u_bsum (
		.clk(clk), .we(we_bsum), .waddr(slot), .wdata(entry_value),
		.raddr(bsum_raddr), .rdata(bsum_rdata)
	);

	btps_ram #(.WIDTH(btps_pkg::OFF_W), .DEPTH(TOTAL)) u_off (
		.clk(clk), .we(we_off), .waddr(slot), .wdata(entry_value[btps_pkg::OFF_W-1:0]),
		.raddr(boff_raddr), .rdata(off_rdata)
	);

	btps_ram #(.WIDTH(SW), .DEPTH(TOTAL)) u_sec (
		.clk(clk), .we(we_sec), .waddr(slot), .wdata(entry_value),
		.raddr(boff_raddr), .rdata(sec_rdata)
	);

	btps_ram #(.WIDTH(btps_pkg::CODE_W), .DEPTH(LEAF_ENTRIES)) u_code (
		.clk(clk), .we(we_code), .waddr(LAW'(idx32)),
		.wdata(entry_value[btps_pkg::CODE_W-1:0]), .raddr(code_raddr), .rdata(code_rdata)
	);

	btps_ram #(.WIDTH(SW), .DEPTH(DICT_ENTRIES)) u_dict (
		.clk(clk), .we(we_dict), .waddr(DAW'(idx32)), .wdata(entry_value),
		.raddr(dict_raddr), .rdata(dict_rdata)
	);

	btps_walk #(
		.MAX_LEVELS    (MAX_LEVELS),
		.LEVEL_ENTRIES (LEVEL_ENTRIES),
		.LEAF_ENTRIES  (LEAF_ENTRIES),
		.DICT_ENTRIES  (DICT_ENTRIES)
	) u_walk (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.query_position (query_position),
		.arity          (arity_q),
		.top_len        (top_len_q),
		.lvl_count      (lvl_count_q),
		.stat           (stat),
		.res_sum        (res_sum),
		.res_take       (res_take),
		.top_raddr      (top_raddr),
		.top_rdata      (top_rdata),
		.flag_raddr     (flag_raddr),
		.flag_rdata     (flag_rdata),
		.bsum_raddr     (bsum_raddr),
		.bsum_rdata     (bsum_rdata),
		.boff_raddr     (boff_raddr),
		.off_rdata      (off_rdata),
		.sec_rdata      (sec_rdata),
		.code_raddr     (code_raddr),
		.code_rdata     (code_rdata),
		.dict_raddr     (dict_raddr),
		.dict_rdata     (dict_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			prefix_sum_q   <= res_sum;
			out_of_range_q <= stat.res_oor;
		end
	end

	assign out_valid    = out_valid_q;
	assign prefix_sum   = prefix_sum_q;
	assign out_of_range = out_of_range_q;

	`BTPS_ASSERT_IMP(a_no_item_while_clearing, clearing_q, !in_ready)
	`BTPS_ASSERT_IMP(a_flagged_sum_zero, out_valid_q && out_of_range_q, prefix_sum_q == '0)
	`BTPS_ASSERT_NXT(a_query_holds_input, in_valid && in_ready && kind == btps_pkg::KIND_QUERY, !in_ready)

endmodule
